### design/idf1_pkg.sv
`default_nettype none

package idf1_pkg;

	// Filter order range and default
	localparam int ORDER_DEF  = 2;
	localparam int ORDER_MAX  = 3;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 18;

	// Register file layout: three coefficient slots per side
	localparam int NREGS_SIDE = 3;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 5;
	localparam int REG_IDX_W  = 3;

	// Accumulator covers 2*ORDER_MAX+1 products of 19x16 bits
	localparam int ACC_W      = 38;
	// Quotient magnitude bits before saturation
	localparam int QMAG_W     = 17;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_B0 = 3'd0;
	localparam reg_idx_t REG_B1 = 3'd1;
	localparam reg_idx_t REG_B2 = 3'd2;
	localparam reg_idx_t REG_A0 = 3'd3;
	localparam reg_idx_t REG_A1 = 3'd4;
	localparam reg_idx_t REG_A2 = 3'd5;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Q3.14 unity
	localparam coef_t COEF_ONE = 18'sd16384;

	// Output limits
	localparam sample_t SAT_MAX = 16'sh7FFF;
	localparam sample_t SAT_MIN = 16'sh8000;

	// Coefficient set handed from the register file to the datapath
	typedef struct packed {
		coef_t [NREGS_SIDE-1:0] b;
		coef_t [NREGS_SIDE-1:0] a;
	} coef_set_t;

endpackage

`default_nettype wire

### design/idf1_in_if.sv
`default_nettype none

interface idf1_in_if;
	import idf1_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### design/idf1_out_if.sv
`default_nettype none

interface idf1_out_if;
	import idf1_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    status;

	modport source (output valid, output sample_out, output status, input ready);
	modport sink (input valid, input sample_out, input status, output ready);
endinterface

`default_nettype wire

### design/idf1_regs.sv
`default_nettype none

module idf1_regs #(
	parameter int ORDER = idf1_pkg::ORDER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [idf1_pkg::ADDR_W-1:0]   paddr,
	input  logic [idf1_pkg::DATA_W-1:0]   pwdata,
	output logic [idf1_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output idf1_pkg::coef_set_t           coefs
);
	import idf1_pkg::*;

	coef_set_t coefs_q;
	reg_idx_t  idx;
	coef_t     wr_word;
	coef_t     rd_word;
	logic      wr_en;

	assign idx     = paddr[ADDR_W-1:2];
	assign wr_word = coef_t'(pwdata[COEF_W-1:0]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign coefs   = coefs_q;

	// Write the addressed coefficient; drop writes to taps beyond the order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.b <= {coef_t'(0), coef_t'(0), COEF_ONE};
			coefs_q.a <= {coef_t'(0), coef_t'(0), COEF_ONE};
		end else if (wr_en) begin
			case (idx)
				REG_B0: coefs_q.b[0] <= wr_word;
				REG_B1: coefs_q.b[1] <= wr_word;
				REG_B2: if (ORDER >= 2) coefs_q.b[2] <= wr_word;
				REG_A0: coefs_q.a[0] <= wr_word;
				REG_A1: coefs_q.a[1] <= wr_word;
				REG_A2: if (ORDER >= 2) coefs_q.a[2] <= wr_word;
				default: ;
			endcase
		end
	end

	// Read back the addressed coefficient, sign extended
	always_comb begin
		case (idx)
			REG_B0:  rd_word = coefs_q.b[0];
			REG_B1:  rd_word = coefs_q.b[1];
			REG_B2:  rd_word = coefs_q.b[2];
			REG_A0:  rd_word = coefs_q.a[0];
			REG_A1:  rd_word = coefs_q.a[1];
			REG_A2:  rd_word = coefs_q.a[2];
			default: rd_word = '0;
		endcase
	end

	assign prdata = {{(DATA_W-COEF_W){rd_word[COEF_W-1]}}, rd_word};

endmodule

`default_nettype wire

### design/iir_direct_form_one_filter.sv
// Direct form I IIR filter, one shared 19x16 multiplier and a bit-serial restoring divider.
// Each accepted sample runs through multiply-accumulate, sign/range and divide steps to
//   a 17-bit quotient magnitude, then finish; a zero divisor goes straight to finish.
// A new sample is accepted only while idle, once the previous result has left finish.
// Reset (arst_n low, asynchronous) clears both histories, the sequencer and the result valid
// flag, and returns every coefficient to its reset value.
`default_nettype none

module iir_direct_form_one_filter #(
	parameter int ORDER = idf1_pkg::ORDER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [idf1_pkg::ADDR_W-1:0]   paddr,
	input  logic [idf1_pkg::DATA_W-1:0]   pwdata,
	output logic [idf1_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	idf1_in_if.sink                       in_ch,
	idf1_out_if.source                    out_ch
);
	import idf1_pkg::*;

	localparam int NTERMS = 2 * ORDER + 1;
	localparam int STEP_W = $clog2(NTERMS + 1);
	localparam int PROD_W = COEF_W + 1 + SAMPLE_W;
	localparam int CNT_W  = $clog2(QMAG_W);
	localparam logic [QMAG_W-1:0] POS_LIM = QMAG_W'(32767);
	localparam logic [QMAG_W-1:0] NEG_LIM = QMAG_W'(32768);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MAC  = 6'b000010,
		S_ABS  = 6'b000100,
		S_CHK  = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	coef_set_t coefs;

	state_t                        state_q;
	logic [STEP_W-1:0]             step_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          pv_q;
	logic                          zero_q;
	logic                          qneg_q;
	logic                          ovf_q;
	sample_t                       x_q;
	logic [ORDER-1:0][SAMPLE_W-1:0] xh_q;
	logic [ORDER-1:0][SAMPLE_W-1:0] yh_q;
	logic signed [ACC_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic [ACC_W-1:0]              mag_q;
	logic [ACC_W-1:0]              dsh_q;
	logic [COEF_W-1:0]             dmag_q;
	logic [QMAG_W-1:0]             qmag_q;

	logic                          out_valid_q;
	sample_t                       sample_out_q;
	logic                          status_q;

	coef_t [ORDER:0]               tb;
	coef_t [ORDER:0]               ta;
	logic signed [COEF_W:0]        op_coef;
	sample_t                       op_data;
	logic signed [PROD_W-1:0]      prod_w;
	sample_t                       y_res;
	logic                          in_fire;
	logic                          out_load;
	logic                          div_ge;

	idf1_regs #(.ORDER(ORDER)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	// Map taps to registers; taps without a register read as zero
	for (genvar k = 0; k <= ORDER; k++) begin : g_tap
		if (k < NREGS_SIDE) begin : g_reg
			assign tb[k] = coefs.b[k];
			assign ta[k] = coefs.a[k];
		end else begin : g_zero
			assign tb[k] = '0;
			assign ta[k] = '0;
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;

	// Select coefficient and sample of the current term; feedback terms are negated
	always_comb begin
		op_coef = '0;
		op_data = '0;
		if (step_q == '0) begin
			op_coef = $signed({tb[0][COEF_W-1], tb[0]});
			op_data = x_q;
		end
		for (int i = 0; i < ORDER; i++) begin
			if (step_q == STEP_W'(i + 1)) begin
				op_coef = $signed({tb[i+1][COEF_W-1], tb[i+1]});
				op_data = sample_t'(xh_q[i]);
			end
			if (step_q == STEP_W'(ORDER + i + 1)) begin
				op_coef = -$signed({ta[i+1][COEF_W-1], ta[i+1]});
				op_data = sample_t'(yh_q[i]);
			end
		end
	end

	assign prod_w = op_coef * op_data;
	assign div_ge = (mag_q >= dsh_q);

	// Saturate the signed quotient to the sample range
	always_comb begin
		if (qneg_q) begin
			if (ovf_q || (qmag_q > NEG_LIM)) begin
				y_res = SAT_MIN;
			end else begin
				y_res = sample_t'(~qmag_q + 1'b1);
			end
		end else begin
			if (ovf_q || (qmag_q > POS_LIM)) begin
				y_res = SAT_MAX;
			end else begin
				y_res = sample_t'(qmag_q);
			end
		end
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// Sequencer and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			pv_q    <= 1'b0;
			zero_q  <= 1'b0;
			qneg_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						step_q  <= '0;
						pv_q    <= 1'b0;
						zero_q  <= (ta[0] == '0);
						state_q <= (ta[0] == '0) ? S_DONE : S_MAC;
					end
				end
				S_MAC: begin
					if (step_q != STEP_W'(NTERMS)) begin
						step_q <= step_q + 1'b1;
						pv_q   <= 1'b1;
					end else begin
						pv_q    <= 1'b0;
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					qneg_q  <= acc_q[ACC_W-1] ^ ta[0][COEF_W-1];
					state_q <= S_CHK;
				end
				S_CHK: begin
					ovf_q   <= (mag_q >= ACC_W'({dmag_q, {QMAG_W{1'b0}}}));
					cnt_q   <= CNT_W'(QMAG_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: capture sample, accumulate products, take magnitudes, divide
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					x_q   <= in_ch.sample_in;
					acc_q <= '0;
				end
			end
			S_MAC: begin
				if (pv_q) begin
					acc_q <= acc_q + prod_q;
				end
				prod_q <= ACC_W'(prod_w);
			end
			S_ABS: begin
				mag_q  <= acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
				dmag_q <= ta[0][COEF_W-1] ? (~ta[0] + 1'b1) : ta[0];
			end
			S_CHK: begin
				dsh_q  <= ACC_W'({dmag_q, {(QMAG_W-1){1'b0}}});
				qmag_q <= '0;
			end
			S_DIV: begin
				if (div_ge) begin
					mag_q <= mag_q - dsh_q;
				end
				qmag_q <= {qmag_q[QMAG_W-2:0], div_ge};
				dsh_q  <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

	// Advance both histories on a valid result; hold them on a zero divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xh_q <= '0;
			yh_q <= '0;
		end else if (out_load && !zero_q) begin
			for (int i = ORDER - 1; i > 0; i--) begin
				xh_q[i] <= xh_q[i-1];
				yh_q[i] <= yh_q[i-1];
			end
			xh_q[0] <= x_q;
			yh_q[0] <= y_res;
		end
	end

	// Result register parts the sequencer from the output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= zero_q ? sample_t'(0) : y_res;
			status_q     <= zero_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = sample_out_q;
	assign out_ch.status     = status_q;

	// A zero divisor skips all arithmetic
	a_zero_skip: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (coefs.a[0] == '0) |=> (state_q == S_DONE) && zero_q)
		else $error("zero divisor item did not go straight to finish");

	// Restoring divider keeps the remainder below twice the shifted divisor
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && !ovf_q |-> (mag_q < (dsh_q << 1)))
		else $error("divider remainder out of range");

	// A zero divisor result leaves the histories untouched
	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && zero_q |=> $stable(xh_q) && $stable(yh_q))
		else $error("history changed on zero divisor");

	// A result appears only from the finish step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result valid raised outside finish");

endmodule

`default_nettype wire
